// ===== rtl/core/bbt_pkg.sv =====
// shared types and constants for the buffer block table
`default_nettype none

package bbt_pkg;

    // fixed field widths of the beats
    localparam int BLOCK_W = 16;
    localparam int INDEX_W = 5;

    // request codes
    localparam logic REQ_ALLOC  = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK            = 2'd0,
        ST_OUT_OF_BOUND  = 2'd1,
        ST_NOT_IN_BUFFER = 2'd2,
        ST_NO_FREE_SLOT  = 2'd3
    } status_t;

    // control sequencer states
    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_CMP,
        FSM_SEL
    } fsm_t;

    // input beat
    typedef struct packed {
        logic               req_type;
        logic [BLOCK_W-1:0] block_num;
    } in_beat_t;

    // result beat
    typedef struct packed {
        status_t            status;
        logic [INDEX_W-1:0] slot_index;
    } out_beat_t;

endpackage

`default_nettype wire

// ===== rtl/core/buffer_block_table.sv =====
// top level of the buffer block table: slot cell row, selection and result register
//
// Usage: a request beat on s_ (s_valid/s_ready, s_data) either allocates the
// lowest free slot for a block number or looks up the lowest occupied slot
// holding it. One result beat per request leaves on m_ (m_valid/m_ready,
// m_data) with a status and the slot index (zero unless status is ok).
// Block numbers at or above DISK_SIZE return out of bound and change nothing.
// An accepted request is captured, its compare vectors are registered in the
// compare step and its result is registered on m_ in the select step. The
// control sequencer takes one request at a time, so no new request is accepted
// until that result is written; the lowest-slot pick and commit happen in the select step.
// Reset (aresetn low, synchronous) frees every slot and clears all ages at
// once; there is no clearing pass. When the receiver holds m_ready low, the
// finished result stays in the output register while the next request may
// still be accepted and compared; it waits in the select step until the
// output register frees up.
`default_nettype none

module buffer_block_table #(
    parameter int SLOTS     = 32,
    parameter int DISK_SIZE = 8192,
    parameter int AGE_BITS  = 16
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire bbt_pkg::in_beat_t  s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output bbt_pkg::out_beat_t      m_data
);
    import bbt_pkg::*;

    localparam int TAG_W = (DISK_SIZE > 2) ? $clog2(DISK_SIZE) : 1;
    localparam int IDX_W = (SLOTS > 2) ? $clog2(SLOTS) : 1;
    localparam logic [BLOCK_W:0] DISK_LIMIT = (BLOCK_W + 1)'(DISK_SIZE);

    fsm_t fsm_reg, fsm_next;

    logic               req_reg;
    logic [BLOCK_W-1:0] blk_reg;
    logic               oob_reg;
    logic [SLOTS-1:0]   hit_vec_reg;
    logic [SLOTS-1:0]   free_vec_reg;

    logic               m_valid_reg, m_valid_next;
    out_beat_t          m_data_reg, m_data_next;

    logic [SLOTS-1:0]   cell_free;
    logic [SLOTS-1:0]   cell_hit;
    logic [SLOTS-1:0]   grant_vec;
    logic               age_en;

    logic [SLOTS-1:0]   pick_vec;
    logic [SLOTS-1:0]   pick_low;
    logic [IDX_W-1:0]   pick_idx;
    logic               pick_any;
    logic               out_free;
    logic               commit;
    logic               accept;
    out_beat_t          result;

    // row of slot cells
    for (genvar i = 0; i < SLOTS; i++) begin : g_cell
        bbt_cell #(
            .TAG_W    (TAG_W),
            .AGE_BITS (AGE_BITS)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .tag_in  (blk_reg[TAG_W-1:0]),
            .age_en  (age_en),
            .grant   (grant_vec[i]),
            .free    (cell_free[i]),
            .hit     (cell_hit[i])
        );
    end

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // lowest set bit of the chosen vector and its index
    always_comb begin
        pick_vec = (req_reg == REQ_LOOKUP) ? hit_vec_reg : free_vec_reg;
        pick_low = pick_vec & (~pick_vec + SLOTS'(1));
        pick_any = |pick_vec;
        pick_idx = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (pick_low[i]) begin
                pick_idx = pick_idx | IDX_W'(i);
            end
        end
    end

    // result beat
    always_comb begin
        result.status     = ST_OK;
        result.slot_index = INDEX_W'(pick_idx);
        if (oob_reg) begin
            result.status     = ST_OUT_OF_BOUND;
            result.slot_index = '0;
        end else if (!pick_any) begin
            result.status     = (req_reg == REQ_LOOKUP) ? ST_NOT_IN_BUFFER : ST_NO_FREE_SLOT;
            result.slot_index = '0;
        end
    end

    // claim and aging happen with the result write
    assign commit    = (fsm_reg == FSM_SEL) && out_free && !oob_reg
                       && (req_reg == REQ_ALLOC) && pick_any;
    assign grant_vec = commit ? pick_low : '0;
    assign age_en    = commit;

    // sequencer next state and output register
    always_comb begin
        fsm_next     = fsm_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (fsm_reg)
            FSM_IDLE: begin
                if (accept) begin
                    fsm_next = FSM_CMP;
                end
            end
            FSM_CMP: begin
                fsm_next = FSM_SEL;
            end
            FSM_SEL: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = result;
                    fsm_next     = FSM_IDLE;
                end
            end
            default: begin
                fsm_next = FSM_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fsm_reg     <= FSM_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            fsm_reg     <= fsm_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // request capture, compare vectors and result payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg <= s_data.req_type;
            blk_reg <= s_data.block_num;
        end
        if (fsm_reg == FSM_CMP) begin
            oob_reg      <= ({1'b0, blk_reg} >= DISK_LIMIT);
            hit_vec_reg  <= cell_hit;
            free_vec_reg <= cell_free;
        end
        m_data_reg <= m_data_next;
    end

    assign s_ready = (fsm_reg == FSM_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

// ===== rtl/core/bbt_cell.sv =====
// one buffer slot: occupied flag, block tag and saturating age counter
`default_nettype none

module bbt_cell #(
    parameter int TAG_W    = 13,
    parameter int AGE_BITS = 16
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic [TAG_W-1:0] tag_in,
    input  wire logic             age_en,
    input  wire logic             grant,
    output logic                  free,
    output logic                  hit
);
    import bbt_pkg::*;

    localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

    logic                used_reg, used_next;
    logic [TAG_W-1:0]    tag_reg, tag_next;
    logic [AGE_BITS-1:0] age_reg, age_next;

    // claim, tag and aging update
    always_comb begin
        used_next = used_reg;
        tag_next  = tag_reg;
        age_next  = age_reg;
        if (grant) begin
            used_next = 1'b1;
            tag_next  = tag_in;
            age_next  = '0;
        end else if (age_en && used_reg && (age_reg != AGE_MAX)) begin
            age_next = age_reg + AGE_BITS'(1);
        end
    end

    // control state and age clear on reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= 1'b0;
            age_reg  <= '0;
        end else begin
            used_reg <= used_next;
            age_reg  <= age_next;
        end
    end

    // tag holds no reset
    always_ff @(posedge aclk) begin
        tag_reg <= tag_next;
    end

    // local compare results
    assign free = !used_reg;
    assign hit  = used_reg && (tag_reg == tag_in);

endmodule

`default_nettype wire

// ===== rtl/core/bbt_checker.sv =====
// port-level checks for the buffer block table and their binding
`default_nettype none

module bbt_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_valid,
    input wire logic               s_ready,
    input wire bbt_pkg::in_beat_t  s_data,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire bbt_pkg::out_beat_t m_data
);
    import bbt_pkg::*;

    // a result that is not ok carries index zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.status != ST_OK)) |-> (m_data.slot_index == '0))
        else $error("non-ok result with nonzero slot index");

    // one request at a time: no accept right after an accept
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted while previous one in flight");

    // a request never completes in the cycle after its beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !m_valid) |=> !m_valid)
        else $error("result appeared too early");

    // a stalled result beat holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("result beat changed while stalled");

    // a waiting request beat holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && !s_ready) |=> (s_valid && $stable(s_data)))
        else $error("request beat changed while waiting");

endmodule

bind buffer_block_table bbt_checker u_bbt_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
